@@ rtl/inline_style_attribute_tokenizer_macros.svh @@
// Assertion macros shared by the style tokenizer RTL.
`ifndef INLINE_STYLE_ATTRIBUTE_TOKENIZER_MACROS_SVH
`define INLINE_STYLE_ATTRIBUTE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clock edge outside reset
`define IST_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IST_ASSERT_IMP(label, ante, cons, msg)
`define IST_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/ist_pkg.sv @@
// Types and constants shared by the style tokenizer modules.
`timescale 1ns / 1ps
package ist_pkg;

   typedef enum logic [1:0] {
      KIND_NAME_CHAR  = 2'd0,
      KIND_VALUE_CHAR = 2'd1,
      KIND_ATTR_END   = 2'd2,
      KIND_STR_END    = 2'd3
   } kind_type;

   // front phase machine states
   typedef enum logic [2:0] {
      PH_LEAD       = 3'd0,
      PH_NAME       = 3'd1,
      PH_AFTER_NAME = 3'd2,
      PH_VALUE_LEAD = 3'd3,
      PH_VALUE      = 3'd4,
      PH_SEP        = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_char;
      logic [7:0]  attr_index;
      logic [4:0]  name_length;
      logic [5:0]  value_length;
      logic [7:0]  attr_count;
      logic        last_of_run;
   } rsp_type;

   // one queue entry: all results of one input beat (at most two)
   typedef struct packed {
      logic    two;
      rsp_type r0;
      rsp_type r1;
   } ent_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

@@ rtl/inline_style_attribute_tokenizer.sv @@
// Top level of the inline style attribute tokenizer.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (req_*): one byte of the style string per beat, taken when
//    req_push is high and req_full is low. req_is_end or a zero byte ends the string.
//  - Result channel (rsp_*): queue-like; the oldest result sits on the rsp_ ports
//    while rsp_empty is low and is taken on rsp_pop. Kinds: name char, value char,
//    attribute end (with lengths), string end (with attribute count).
//  - csr_wr_en/csr_wr_data write max_attrs (reset 16); write only while idle.
//  - Path: a result goes through the queue write, then the output register load,
//    before it is on the rsp_ ports; a full output register keeps it in the queue.
//  - Throughput: one input beat per cycle while req_full is low, one result beat
//    per cycle while the receiver pops. A beat that yields two results (attribute
//    end plus string end or plus the next name char) leaves as two result beats;
//    the four-entry queue absorbs short runs of these, a long run holds input back.
//  - Reset (sync, active high) clears the phase machine, the queue and the
//    output register; max_attrs returns to 16.
//  - When the receiver stalls, results pile up in the queue; req_full rises once
//    the queue is full and nothing is lost or repeated.
module inline_style_attribute_tokenizer #(
   parameter int NAME_MAX_LEN  = 32,
   parameter int VALUE_MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_ch,
   input  logic       req_is_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_char,
   output logic [7:0] rsp_attr_index,
   output logic [4:0] rsp_name_length,
   output logic [5:0] rsp_value_length,
   output logic [7:0] rsp_attr_count,
   output logic       rsp_last_of_run
);

   // front -> queue
   logic             q_push, q_full;
   ist_pkg::ent_type q_wdata;
   // queue -> back
   logic             q_pop, q_empty;
   ist_pkg::ent_type q_head;
   ist_pkg::rsp_type rsp;

   ist_front #(
      .NAME_MAX_LEN  (NAME_MAX_LEN),
      .VALUE_MAX_LEN (VALUE_MAX_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_ch      (req_ch),
      .req_is_end  (req_is_end),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   ist_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ist_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // unpack the result beat onto its field ports
   assign rsp_kind         = rsp.kind;
   assign rsp_out_char     = rsp.out_char;
   assign rsp_attr_index   = rsp.attr_index;
   assign rsp_name_length  = rsp.name_length;
   assign rsp_value_length = rsp.value_length;
   assign rsp_attr_count   = rsp.attr_count;
   assign rsp_last_of_run  = rsp.last_of_run;

endmodule

@@ rtl/ist_front.sv @@
// Front end: config register, phase machine, packs the results of each input beat.
`timescale 1ns / 1ps
`include "inline_style_attribute_tokenizer_macros.svh"
module ist_front #(
   parameter int NAME_MAX_LEN  = 32,
   parameter int VALUE_MAX_LEN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      req_ch,
   input  logic            req_is_end,
   input  logic            q_full,
   output logic            q_push,
   output ist_pkg::ent_type q_data
);

   localparam int NW = ($clog2(NAME_MAX_LEN) > 5) ? $clog2(NAME_MAX_LEN) : 5;
   localparam int VW = ($clog2(VALUE_MAX_LEN) > 6) ? $clog2(VALUE_MAX_LEN) : 6;
   localparam logic [NW-1:0] NAME_LIM  = NW'(NAME_MAX_LEN - 1);
   localparam logic [VW-1:0] VALUE_LIM = VW'(VALUE_MAX_LEN - 1);
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_NUL   = 8'h00;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'd32) || (c inside {[8'd9:8'd13]});
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[8'd65:8'd90]}) ? (c + 8'd32) : c;
   endfunction

   ist_pkg::phase_type phase_ff, phase_in;
   logic [7:0]      count_ff, count_in;
   logic [NW-1:0]   name_ff, name_in;
   logic [VW-1:0]   value_ff, value_in;
   logic [VW-1:0]   trim_ff, trim_in;
   logic [7:0]      max_attrs_ff;

   logic            accept, term, ws, colon, semi;
   logic [7:0]      lc, count_inc, start_cnt;
   logic            do_end, do_start, do_value, emit_b;
   ist_pkg::rsp_type rec_a, rec_b;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign term      = req_is_end || (req_ch == CH_NUL);
   assign ws        = is_ws(req_ch);
   assign colon     = (req_ch == CH_COLON);
   assign semi      = (req_ch == CH_SEMI);
   assign lc        = to_lower(req_ch);
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      name_in   = name_ff;
      value_in  = value_ff;
      trim_in   = trim_ff;
      do_end    = 1'b0;
      do_start  = 1'b0;
      do_value  = 1'b0;
      start_cnt = count_ff;
      emit_b    = 1'b0;
      rec_b     = '0;
      if (term) begin
         do_end = phase_ff inside {ist_pkg::PH_NAME, ist_pkg::PH_AFTER_NAME,
                                   ist_pkg::PH_VALUE_LEAD, ist_pkg::PH_VALUE};
         emit_b = 1'b1;
         rec_b.kind       = ist_pkg::KIND_STR_END;
         rec_b.attr_count = do_end ? count_inc : count_ff;
         phase_in = ist_pkg::PH_LEAD;
         count_in = '0;
         name_in  = '0;
         value_in = '0;
         trim_in  = '0;
      end else begin
         case (phase_ff)
            ist_pkg::PH_LEAD, ist_pkg::PH_SEP: begin
               if (!ws && !(phase_ff == ist_pkg::PH_SEP && semi)) do_start = 1'b1;
            end
            ist_pkg::PH_NAME: begin
               if (colon) begin
                  phase_in = ist_pkg::PH_VALUE_LEAD;
               end else if (ws) begin
                  phase_in = ist_pkg::PH_AFTER_NAME;
               end else if (name_ff < NAME_LIM) begin
                  name_in          = name_ff + NW'(1);
                  emit_b           = 1'b1;
                  rec_b.kind       = ist_pkg::KIND_NAME_CHAR;
                  rec_b.out_char   = lc;
                  rec_b.attr_index = count_ff;
               end
            end
            ist_pkg::PH_AFTER_NAME: begin
               if (colon) begin
                  phase_in = ist_pkg::PH_VALUE_LEAD;
               end else if (semi) begin
                  do_end = 1'b1;
               end else if (!ws) begin
                  // name, blanks, then a new name: close this one, open the next
                  do_end   = 1'b1;
                  do_start = 1'b1;
               end
            end
            ist_pkg::PH_VALUE_LEAD: begin
               if (semi) begin
                  do_end = 1'b1;
               end else if (!ws) begin
                  phase_in = ist_pkg::PH_VALUE;
                  do_value = 1'b1;
               end
            end
            ist_pkg::PH_VALUE: begin
               if (semi) do_end = 1'b1;
               else      do_value = 1'b1;
            end
            default: ;
         endcase

         if (do_value && (value_ff < VALUE_LIM)) begin
            value_in         = value_ff + VW'(1);
            if (!ws) trim_in = value_ff + VW'(1);
            emit_b           = 1'b1;
            rec_b.kind       = ist_pkg::KIND_VALUE_CHAR;
            rec_b.out_char   = lc;
            rec_b.attr_index = count_ff;
         end

         if (do_end) begin
            count_in  = count_inc;
            phase_in  = (count_inc >= max_attrs_ff) ? ist_pkg::PH_DONE : ist_pkg::PH_SEP;
            start_cnt = count_inc;
         end

         if (do_start) begin
            if (start_cnt >= max_attrs_ff) begin
               phase_in = ist_pkg::PH_DONE;
            end else begin
               name_in  = '0;
               value_in = '0;
               trim_in  = '0;
               if (colon) begin
                  phase_in = ist_pkg::PH_VALUE_LEAD;
               end else begin
                  phase_in         = ist_pkg::PH_NAME;
                  name_in          = NW'(1);
                  emit_b           = 1'b1;
                  rec_b.kind       = ist_pkg::KIND_NAME_CHAR;
                  rec_b.out_char   = lc;
                  rec_b.attr_index = start_cnt;
               end
            end
         end
      end
   end

   always_comb begin
      rec_a              = '0;
      rec_a.kind         = ist_pkg::KIND_ATTR_END;
      rec_a.attr_index   = count_ff;
      rec_a.name_length  = name_ff[4:0];
      rec_a.value_length = trim_ff[5:0];
      rec_a.last_of_run  = !emit_b;
   end

   always_comb begin
      q_data.two            = do_end && emit_b;
      q_data.r0             = do_end ? rec_a : rec_b;
      q_data.r1             = rec_b;
      q_data.r1.last_of_run = 1'b1;
      if (!do_end) q_data.r0.last_of_run = 1'b1;
   end

   assign q_push = accept && (do_end || emit_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ist_pkg::PH_LEAD;
         count_ff     <= '0;
         name_ff      <= '0;
         value_ff     <= '0;
         trim_ff      <= '0;
         max_attrs_ff <= 8'd16;
      end else begin
         if (csr_wr_en) max_attrs_ff <= csr_wr_data;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            name_ff  <= name_in;
            value_ff <= value_in;
            trim_ff  <= trim_in;
         end
      end
   end

   `IST_ASSERT_IMP(a_pair_opens_with_end, q_push && q_data.two,
      q_data.r0.kind == ist_pkg::KIND_ATTR_END, "result pair does not start with attr end")
   `IST_ASSERT_IMP(a_name_in_range, 1'b1, name_ff <= NAME_LIM,
      "stored name length beyond limit")

endmodule

@@ rtl/ist_fifo.sv @@
// Short queue of packed result entries between front and back.
`timescale 1ns / 1ps
`include "inline_style_attribute_tokenizer_macros.svh"
module ist_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ist_pkg::ent_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output ist_pkg::ent_type head
);

   localparam int DEPTH = ist_pkg::QUEUE_DEPTH;
   localparam int PW    = ist_pkg::QPTR_W;

   ist_pkg::ent_type mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (PW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      end
   end

   `IST_ASSERT_IMP(a_no_push_when_full, push, !full, "push into a full queue")
   `IST_ASSERT_IMP(a_count_bound, 1'b1, cnt_ff <= (PW+1)'(DEPTH), "queue count overflow")

endmodule

@@ rtl/ist_back.sv @@
// Back end: unpacks queue entries into single result beats behind an output register.
`timescale 1ns / 1ps
`include "inline_style_attribute_tokenizer_macros.svh"
module ist_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  ist_pkg::ent_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ist_pkg::rsp_type rsp
);

   logic             out_valid_ff, out_valid_in;
   logic             sel_ff, sel_in;
   ist_pkg::rsp_type out_ff, out_in;
   logic             load, taken;

   assign taken     = rsp_pop && out_valid_ff;
   assign load      = !q_empty && (!out_valid_ff || taken);
   assign q_pop     = load && (sel_ff || !q_head.two);
   assign out_in    = sel_ff ? q_head.r1 : q_head.r0;
   assign sel_in    = load ? (!sel_ff && q_head.two) : sel_ff;
   assign out_valid_in = load ? 1'b1 : (taken ? 1'b0 : out_valid_ff);

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (load) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sel_ff       <= sel_in;
      end
   end

   `IST_ASSERT_IMP(a_sel_on_pair, sel_ff, !q_empty && q_head.two,
      "second half selected without a pair at the head")
   `IST_ASSERT_IMP(a_first_of_pair_not_last, out_valid_ff && sel_ff, !out_ff.last_of_run,
      "first result of a pair flagged as last")

endmodule

@@ dv/tb_inline_style_attribute_tokenizer.sv @@
// Self-checking testbench for the inline style attribute tokenizer.
`timescale 1ns / 1ps

module tb_inline_style_attribute_tokenizer;

   localparam int NAME_CAP    = 32;
   localparam int VALUE_CAP   = 64;
   localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the run length
   localparam int SETTLE      = 8;       // extra wait once every result has been seen
   localparam int HOLD_SPAN   = 400;     // long receiver hold-off, in cycles

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_DIG_0 = 8'h30;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   // where the scanner sits inside the current string
   typedef enum logic [2:0] {
      SCAN_LEAD,     // skipping leading whitespace
      SCAN_NAME,     // collecting name characters
      SCAN_GAP,      // whitespace seen after a name
      SCAN_VLEAD,    // after the colon, dropping whitespace
      SCAN_VALUE,    // collecting value characters
      SCAN_SEP,      // attribute closed, waiting for the next one
      SCAN_OFF       // attribute limit reached, ignore until string end
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } style_beat_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_push    = 1'b0;
   logic       req_full;
   logic [7:0] req_ch      = 8'd0;
   logic       req_is_end  = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop     = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_char;
   logic [7:0] rsp_attr_index;
   logic [4:0] rsp_name_length;
   logic [5:0] rsp_value_length;
   logic [7:0] rsp_attr_count;
   logic       rsp_last_of_run;

   inline_style_attribute_tokenizer #(
      .NAME_MAX_LEN (NAME_CAP),
      .VALUE_MAX_LEN(VALUE_CAP)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ch          (req_ch),
      .req_is_end      (req_is_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_attr_index  (rsp_attr_index),
      .rsp_name_length (rsp_name_length),
      .rsp_value_length(rsp_value_length),
      .rsp_attr_count  (rsp_attr_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // stimulus and scoreboard storage
   style_beat_type   style_bytes_q[$];   // bytes waiting to be offered
   ist_pkg::rsp_type tokens_due[$];      // predicted results, oldest first
   ist_pkg::rsp_type beat_tokens[$];     // results of the beat being predicted
   style_beat_type   drv_beat;

   // tokenizer shadow state
   scan_phase_type scan    = SCAN_LEAD;
   int          attrs_done = 0;
   int          name_cnt   = 0;
   int          value_cnt  = 0;
   int          value_trim = 0;
   int          max_attrs_cfg = 16;

   // run control
   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_asks  = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int n_queued   = 0;
   int beats_sent = 0;
   int tokens_checked = 0;
   int strings_closed = 0;
   int mismatches = 0;
   int cycle_cnt  = 0;

   // ---------------------------------------------------------------- predictor

   function automatic bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
   endfunction

   function void add_token(ist_pkg::kind_type k, logic [7:0] c, int idx, int nl, int vl,
                           int cnt);
      ist_pkg::rsp_type r;
      r.kind         = k;
      r.out_char     = c;
      r.attr_index   = idx[7:0];
      r.name_length  = nl[4:0];
      r.value_length = vl[5:0];
      r.attr_count   = cnt[7:0];
      r.last_of_run  = 1'b0;
      beat_tokens.push_back(r);
   endfunction

   // attribute end result; the count wraps at eight bits like the block's counter
   function void close_attr(scan_phase_type follow);
      add_token(ist_pkg::KIND_ATTR_END, CH_NUL, attrs_done, name_cnt, value_trim, 0);
      attrs_done = (attrs_done + 1) & 8'hFF;
      scan = (attrs_done >= max_attrs_cfg) ? SCAN_OFF : follow;
   endfunction

   // c is a start byte: neither whitespace nor terminator
   function void open_attr(logic [7:0] c);
      if (attrs_done >= max_attrs_cfg) begin
         scan = SCAN_OFF;
         return;
      end
      name_cnt   = 0;
      value_cnt  = 0;
      value_trim = 0;
      if (c == CH_COLON) begin
         scan = SCAN_VLEAD;   // empty name
         return;
      end
      scan     = SCAN_NAME;
      name_cnt = 1;
      add_token(ist_pkg::KIND_NAME_CHAR, to_lower(c), attrs_done, 0, 0, 0);
   endfunction

   function void put_value(logic [7:0] c);
      if (value_cnt < VALUE_CAP - 1) begin
         value_cnt++;
         if (!is_space(c))
            value_trim = value_cnt;
         add_token(ist_pkg::KIND_VALUE_CHAR, to_lower(c), attrs_done, 0, 0, 0);
      end
   endfunction

   // work out every result of one accepted byte beat and queue them
   function void tokenize_beat(logic [7:0] c, logic is_end);
      ist_pkg::rsp_type r;
      beat_tokens.delete();
      if (is_end || c == CH_NUL) begin
         if (scan inside {SCAN_NAME, SCAN_GAP, SCAN_VLEAD, SCAN_VALUE})
            close_attr(SCAN_SEP);
         add_token(ist_pkg::KIND_STR_END, CH_NUL, 0, 0, 0, attrs_done);
         scan       = SCAN_LEAD;
         attrs_done = 0;
         name_cnt   = 0;
         value_cnt  = 0;
         value_trim = 0;
      end else begin
         case (scan)
            SCAN_LEAD, SCAN_SEP: begin
               if (!is_space(c) && !(scan == SCAN_SEP && c == CH_SEMI))
                  open_attr(c);
            end
            SCAN_NAME: begin
               if (c == CH_COLON)
                  scan = SCAN_VLEAD;
               else if (is_space(c))
                  scan = SCAN_GAP;
               else if (name_cnt < NAME_CAP - 1) begin
                  name_cnt++;
                  add_token(ist_pkg::KIND_NAME_CHAR, to_lower(c), attrs_done, 0, 0, 0);
               end
            end
            SCAN_GAP: begin
               if (c == CH_COLON)
                  scan = SCAN_VLEAD;
               else if (c == CH_SEMI)
                  close_attr(SCAN_SEP);
               else if (!is_space(c)) begin
                  // bare name: close it and start the next one on the same beat
                  close_attr(SCAN_SEP);
                  if (scan != SCAN_OFF)
                     open_attr(c);
               end
            end
            SCAN_VLEAD: begin
               if (c == CH_SEMI)
                  close_attr(SCAN_SEP);
               else if (!is_space(c)) begin
                  scan = SCAN_VALUE;
                  put_value(c);
               end
            end
            SCAN_VALUE: begin
               if (c == CH_SEMI)
                  close_attr(SCAN_SEP);
               else
                  put_value(c);
            end
            default: ;
         endcase
      end
      if (beat_tokens.size() != 0) begin
         r = beat_tokens.pop_back();
         r.last_of_run = 1'b1;
         beat_tokens.push_back(r);
      end
      foreach (beat_tokens[i])
         tokens_due.push_back(beat_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- checking

   function void check_field(string fname, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", fname, want, seen);
         mismatches++;
      end
   endfunction

   function void check_token();
      ist_pkg::rsp_type want;
      if (tokens_due.size() == 0) begin
         $error("result beat with nothing expected: kind %0d char %0d", rsp_kind, rsp_out_char);
         mismatches++;
         return;
      end
      want = tokens_due.pop_front();
      tokens_checked++;
      if (want.kind == ist_pkg::KIND_STR_END)
         strings_closed++;
      check_field("kind",         8'(want.kind),         8'(rsp_kind));
      check_field("out_char",     want.out_char,         rsp_out_char);
      check_field("attr_index",   want.attr_index,       rsp_attr_index);
      check_field("name_length",  8'(want.name_length),  8'(rsp_name_length));
      check_field("value_length", 8'(want.value_length), 8'(rsp_value_length));
      check_field("attr_count",   want.attr_count,       rsp_attr_count);
      check_field("last_of_run",  8'(want.last_of_run),  8'(rsp_last_of_run));
   endfunction

   // ---------------------------------------------------------------- driver
   // A held beat stays on the port until the block takes it; otherwise the next
   // byte goes out unless the sender chooses to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            tokenize_beat(req_ch, req_is_end);
            beats_sent++;
         end
         if (!(req_push && req_full)) begin
            if (style_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               drv_beat   = style_bytes_q.pop_front();
               req_push   <= 1'b1;
               req_ch     <= drv_beat.ch;
               req_is_end <= drv_beat.is_end;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_token();
         rsp_pop <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering bytes
   // and the result queue backs up into req_full.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_left <= HOLD_SPAN;
         hold_seen <= hold_asks;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout: %0d results still expected after %0d cycles",
                  tokens_due.size(), cycle_cnt);
         $display("[inline_style_attribute_tokenizer] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_chr(logic [7:0] c);
      style_bytes_q.push_back('{ch: c, is_end: 1'b0});
      n_queued++;
   endtask

   // terminator beat; the byte rides along and must be ignored
   task automatic push_end(logic [7:0] c);
      style_bytes_q.push_back('{ch: c, is_end: 1'b1});
      n_queued++;
   endtask

   task automatic push_text(string txt);
      int i;
      for (i = 0; i < txt.len(); i++)
         push_chr(txt[i]);
   endtask

   function automatic logic [7:0] rand_space();
      int r;
      r = $urandom_range(5);
      return (r == 0) ? CH_SPACE : 8'(8 + r);   // space, or TAB..CR
   endfunction

   function automatic logic [7:0] rand_name_char();
      logic [7:0] c;
      case ($urandom_range(8))
         0, 1, 2: c = CH_LO_A + 8'($urandom_range(25));
         3:       c = CH_UP_A + 8'($urandom_range(25));
         4:       c = CH_DIG_0 + 8'($urandom_range(9));
         5:       c = CH_DASH;
         6:       c = CH_SEMI;   // legal inside a name
         7:       c = 8'($urandom_range(255, 128));
         default: begin
            c = 8'($urandom_range(255, 1));
            while (is_space(c) || c == CH_COLON)
               c = 8'($urandom_range(255, 1));
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] rand_value_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0, 1:    c = CH_LO_A + 8'($urandom_range(25));
         2:       c = CH_UP_A + 8'($urandom_range(25));
         3:       c = CH_DIG_0 + 8'($urandom_range(9));
         4:       c = rand_space();   // inner whitespace counts, trailing is trimmed
         5:       c = CH_COLON;
         6:       c = 8'($urandom_range(255, 128));
         default: begin
            c = 8'($urandom_range(255, 1));
            while (c == CH_SEMI)
               c = 8'($urandom_range(255, 1));
         end
      endcase
      return c;
   endfunction

   // one style string with random content; optionally left open at the end
   task automatic gen_style(int n_attrs, bit closed);
      int a, nlen, vlen, form;
      repeat ($urandom_range(2)) push_chr(rand_space());
      for (a = 0; a < n_attrs; a++) begin
         nlen = ($urandom_range(19) == 0) ? $urandom_range(40, 28) : $urandom_range(8);
         repeat (nlen) push_chr(rand_name_char());
         form = (nlen == 0) ? 9 : $urandom_range(9);
         if (form == 0) begin
            // name, whitespace, separator: empty value without a colon
            repeat ($urandom_range(2, 1)) push_chr(rand_space());
            push_chr(CH_SEMI);
         end else if (form == 1) begin
            // bare name; the next name opens on the beat that closes this one
            push_chr(rand_space());
         end else begin
            if ($urandom_range(3) == 0)
               push_chr(rand_space());
            push_chr(CH_COLON);
            repeat ($urandom_range(2)) push_chr(rand_space());
            vlen = ($urandom_range(19) == 0) ? $urandom_range(72, 60) : $urandom_range(10);
            repeat (vlen) push_chr(rand_value_char());
            repeat ($urandom_range(2)) push_chr(rand_space());
            if (a != n_attrs - 1 || $urandom_range(1))
               push_chr(CH_SEMI);
            if ($urandom_range(3) == 0)
               push_chr(rand_space());
            if ($urandom_range(9) == 0)
               push_chr(CH_SEMI);
         end
      end
      if (closed) begin
         if ($urandom_range(2) == 0)
            push_chr(CH_NUL);
         else
            push_end(8'($urandom_range(255)));
      end
   endtask

   // byte soup weighted toward the characters the scanner cares about
   task automatic gen_noise();
      repeat ($urandom_range(6, 1)) begin
         case ($urandom_range(5))
            0:       push_chr(CH_COLON);
            1:       push_chr(CH_SEMI);
            2:       push_chr(rand_space());
            default: push_chr(8'($urandom_range(255, 1)));
         endcase
      end
      if ($urandom_range(3) == 0)
         push_end(8'($urandom_range(255)));
   endtask

   task automatic fill_random(int target);
      int start;
      start = n_queued;
      while (n_queued - start < target) begin
         if ($urandom_range(99) < 85)
            gen_style(($urandom_range(15) == 0) ? $urandom_range(20, 14) : $urandom_range(6),
                      1'b1);
         else
            gen_noise();
      end
   endtask

   // quiet point: every byte taken, every result seen, pipeline flushed
   task automatic wait_quiet();
      do @(negedge clock);
      while (style_bytes_q.size() != 0 || req_push || tokens_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_max_attrs(logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      max_attrs_cfg = v;
      @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats at reset max_attrs (16), no idling.
      // Leading whitespace, ';' inside a name, then a bare name followed by
      // another character: attribute end and the new name char on one beat.
      push_text(" \t\nA;b c");
      // Colon, VT and FF dropped, uppercase lowered and 0xFF kept, trailing space/CR trimmed;
      // a zero byte in the middle of a value ends both attribute and string.
      push_text(":");
      push_chr(8'h0B);
      push_chr(8'h0C);
      push_text("V");
      push_chr(8'hFF);
      push_text(" ");
      push_chr(8'h0D);
      push_chr(CH_NUL);
      // empty name, bare name closed by whitespace then ';', end flag with a byte
      push_text(":q;Z :a;k ;");
      push_end(8'hFF);

      fill_random(280);
      gen_style(6, 1'b0);   // string left open across the register write
      wait_quiet();

      // limit drops below the count of the open string: no further starts
      write_max_attrs(8'd3);
      idle_pct = 72;
      fill_random(230);
      wait_quiet();

      // top of range, with a long hold-off that backs the block up
      write_max_attrs(8'd255);
      idle_pct  = 0;
      stall_pct = 72;
      hold_asks++;
      fill_random(230);
      gen_style(4, 1'b0);
      wait_quiet();

      // zero: no new attribute starts, so apart from the open string's tail only string ends
      write_max_attrs(8'd0);
      idle_pct  = 25;
      stall_pct = 25;
      fill_random(110);
      wait_quiet();

      write_max_attrs(8'd1);
      idle_pct  = 0;
      stall_pct = 0;
      fill_random(170);
      wait_quiet();

      write_max_attrs(8'd2);
      idle_pct  = 25;
      stall_pct = 25;
      fill_random(190);
      wait_quiet();

      $display("tokenizer run: %0d byte beats in, %0d results checked, %0d strings closed",
               beats_sent, tokens_checked, strings_closed);
      $display("attribute limits 16/3/255/0/1/2, idle and stall mixes, one long output hold");
      if (mismatches == 0)
         $display("[inline_style_attribute_tokenizer] OK");
      else
         $display("[inline_style_attribute_tokenizer] ERROR");
      $finish;
   end

endmodule
